@@ design/pirl_pkg.sv @@
`timescale 1ns / 1ps

package pirl_pkg;

	typedef enum logic [1:0] {
		KIND_INSERT = 2'd0,
		KIND_REMOVE = 2'd1,
		KIND_DUMP   = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_INDEX = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// per-cycle command broadcast to every cell of the chain
	typedef enum logic [1:0] {
		CMD_HOLD,
		CMD_INSERT,
		CMD_REMOVE,
		CMD_ROTATE
	} cell_cmd_t;

	typedef enum logic {
		S_IDLE,
		S_DUMP
	} state_t;

	localparam int unsigned DATA_W  = 32;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned POS_W   = 7;
	localparam int unsigned COUNT_W = 7;

endpackage

@@ design/positional_insert_remove_list_core.sv @@
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries held in a row of cells,
// one entry per cell, with the entry count in a register. A request transfer
// carries kind (insert, remove, dump), position and item. Insert and remove
// move every cell at once and give one response per request. Dump rotates
// the list through cell 0 one step per cycle while the response side is not
// stalled, so it gives one response per entry (last marks the final one) and
// the list is back in place when done; while it runs req_stall is high. An
// empty list dumps as a single response without a value. Bad positions
// report an index status, insert into a full list reports full; neither
// changes the list. The response side has one output register, so a
// request is taken while the previous response still waits, as long as
// that response is not stalled.
module positional_insert_remove_list_core #(
	parameter int unsigned DEPTH = 64
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              req_valid,
	output logic                              req_stall,
	input  logic [pirl_pkg::KIND_W-1:0]       kind,
	input  logic [pirl_pkg::POS_W-1:0]        position,
	input  logic signed [pirl_pkg::DATA_W-1:0] item,
	output logic                              rsp_valid,
	input  logic                              rsp_stall,
	output logic [1:0]                        status,
	output logic signed [pirl_pkg::DATA_W-1:0] value,
	output logic                              holds_value,
	output logic [pirl_pkg::COUNT_W-1:0]      entry_count,
	output logic                              last
);

	// count holds 0..DEPTH; compares run at the wider of count and position
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > pirl_pkg::POS_W) ? CW : pirl_pkg::POS_W;
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pirl_pkg::state_t state_q, state_d;
	logic [CW-1:0] count_q, count_d;
	logic [CW-1:0] idx_q, idx_d;

	logic                        rsp_valid_q;
	logic [1:0]                  status_q;
	logic [pirl_pkg::DATA_W-1:0] value_q;
	logic                        holds_q;
	logic [pirl_pkg::COUNT_W-1:0] cnt_q;
	logic                        last_q;

	// response register load
	logic                        rsp_load;
	logic [1:0]                  status_d;
	logic [pirl_pkg::DATA_W-1:0] value_d;
	logic                        holds_d;
	logic                        last_d;

	logic                        rsp_free;
	logic                        req_xfer;
	pirl_pkg::cell_cmd_t         cmd;
	logic [PW-1:0]               pos_ext;
	logic [PW-1:0]               cnt_ext;
	logic [PW-1:0]               tail;
	logic                        dump_end;

	logic [pirl_pkg::DATA_W-1:0] cell_data [DEPTH];

	assign rsp_free  = !rsp_valid_q || !rsp_stall;
	assign req_stall = (state_q != pirl_pkg::S_IDLE) || !rsp_free;
	assign req_xfer  = req_valid && !req_stall;
	assign pos_ext   = PW'(position);
	assign cnt_ext   = PW'(count_q);
	assign tail      = cnt_ext - PW'(1);
	assign dump_end  = (idx_q + CW'(1)) == count_q;

	always_comb begin
		state_d  = state_q;
		count_d  = count_q;
		idx_d    = idx_q;
		cmd      = pirl_pkg::CMD_HOLD;
		rsp_load = 1'b0;
		status_d = pirl_pkg::ST_OK;
		value_d  = '0;
		holds_d  = 1'b0;
		last_d   = 1'b1;
		case (state_q)
			pirl_pkg::S_IDLE: begin
				if (req_xfer) begin
					rsp_load = 1'b1;
					case (kind)
						pirl_pkg::KIND_INSERT: begin
							if (pos_ext > cnt_ext) begin
								status_d = pirl_pkg::ST_INDEX;
							end else if (count_q == FULL_CNT) begin
								status_d = pirl_pkg::ST_FULL;
							end else begin
								cmd     = pirl_pkg::CMD_INSERT;
								count_d = count_q + CW'(1);
							end
						end
						pirl_pkg::KIND_REMOVE: begin
							if (pos_ext >= cnt_ext) begin
								status_d = pirl_pkg::ST_INDEX;
							end else begin
								cmd     = pirl_pkg::CMD_REMOVE;
								count_d = count_q - CW'(1);
							end
						end
						pirl_pkg::KIND_DUMP: begin
							// non-empty dump streams from the S_DUMP state on
							if (count_q != '0) begin
								rsp_load = 1'b0;
								idx_d    = '0;
								state_d  = pirl_pkg::S_DUMP;
							end
						end
						default: begin
							rsp_load = 1'b1;
						end
					endcase
				end
			end
			pirl_pkg::S_DUMP: begin
				if (rsp_free) begin
					cmd      = pirl_pkg::CMD_ROTATE;
					rsp_load = 1'b1;
					value_d  = cell_data[0];
					holds_d  = 1'b1;
					last_d   = dump_end;
					idx_d    = idx_q + CW'(1);
					if (dump_end) begin
						state_d = pirl_pkg::S_IDLE;
					end
				end
			end
			default: begin
				state_d = pirl_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pirl_pkg::S_IDLE;
			count_q     <= '0;
			idx_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// response payload, no reset needed
	always_ff @(posedge clk) begin
		if (rsp_load) begin
			status_q <= status_d;
			value_q  <= value_d;
			holds_q  <= holds_d;
			cnt_q    <= pirl_pkg::COUNT_W'(count_d);
			last_q   <= last_d;
		end
	end

	// the cell chain; ends of the chain tie to item (never used) and head
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [pirl_pkg::DATA_W-1:0] left_n;
		logic [pirl_pkg::DATA_W-1:0] right_n;
		if (i == 0) begin : g_first
			assign left_n = item;
		end else begin : g_mid_l
			assign left_n = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_final
			assign right_n = cell_data[0];
		end else begin : g_mid_r
			assign right_n = cell_data[i+1];
		end
		pirl_cell #(
			.IDX (i),
			.PW  (PW)
		) u_cell (
			.clk   (clk),
			.cmd   (cmd),
			.pos   (pos_ext),
			.tail  (tail),
			.item  (item),
			.left  (left_n),
			.right (right_n),
			.head  (cell_data[0]),
			.data  (cell_data[i])
		);
	end

	assign rsp_valid   = rsp_valid_q;
	assign status      = status_q;
	assign value       = value_q;
	assign holds_value = holds_q;
	assign entry_count = cnt_q;
	assign last        = last_q;

endmodule

@@ design/pirl_cell.sv @@
`timescale 1ns / 1ps

// One list slot. Insert: item at pos, left neighbor above pos. Remove: right
// neighbor from pos up. Rotate: right neighbor; the tail slot takes the head.
module pirl_cell #(
	parameter int unsigned IDX = 0,
	parameter int unsigned PW  = 7
) (
	input  logic                           clk,
	input  pirl_pkg::cell_cmd_t            cmd,
	input  logic [PW-1:0]                  pos,
	input  logic [PW-1:0]                  tail,
	input  logic [pirl_pkg::DATA_W-1:0]    item,
	input  logic [pirl_pkg::DATA_W-1:0]    left,
	input  logic [pirl_pkg::DATA_W-1:0]    right,
	input  logic [pirl_pkg::DATA_W-1:0]    head,
	output logic [pirl_pkg::DATA_W-1:0]    data
);

	localparam logic [PW-1:0] MY_IDX = PW'(IDX);

	logic [pirl_pkg::DATA_W-1:0] data_q;
	logic [pirl_pkg::DATA_W-1:0] data_d;

	always_comb begin
		data_d = data_q;
		case (cmd)
			pirl_pkg::CMD_INSERT: begin
				if (MY_IDX == pos) begin
					data_d = item;
				end else if (MY_IDX > pos) begin
					data_d = left;
				end
			end
			pirl_pkg::CMD_REMOVE: begin
				if (MY_IDX >= pos) begin
					data_d = right;
				end
			end
			pirl_pkg::CMD_ROTATE: begin
				data_d = (MY_IDX == tail) ? head : right;
			end
			default: begin
				data_d = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_d;
	end

	assign data = data_q;

endmodule

@@ design/pirl_checker.sv @@
`timescale 1ns / 1ps

module pirl_checker #(
	parameter int unsigned DEPTH = 64
) (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              rsp_valid,
	input logic                              rsp_stall,
	input logic [1:0]                        status,
	input logic signed [pirl_pkg::DATA_W-1:0] value,
	input logic                              holds_value,
	input logic [pirl_pkg::COUNT_W-1:0]      entry_count,
	input logic                              last
);

	// stalled response stays put
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(value) && $stable(last)
			&& $stable(status))
		else $error("response changed while stalled");

	a_no_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !holds_value |-> value == '0 && last)
		else $error("response without entry carries data or is not last");

	a_err_single: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status != pirl_pkg::ST_OK |-> !holds_value)
		else $error("error response carries an entry");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == pirl_pkg::ST_FULL
			|-> entry_count == pirl_pkg::COUNT_W'(DEPTH))
		else $error("full reported below capacity");

endmodule

bind positional_insert_remove_list_core pirl_checker #(.DEPTH(DEPTH)) u_pirl_checker (.*);

@@ bench/tb_positional_insert_remove_list_core.sv @@
`timescale 1ns / 1ps

module tb_positional_insert_remove_list_core;

	localparam int unsigned DEPTH        = 64;
	localparam logic [1:0]  KIND_UNUSED  = 2'd3;   // no operation behind this code
	localparam int          DUMP_SETTLE  = DEPTH + 6;
	localparam int          LIMIT_CYCLES = 400000;
	localparam int          RANDOM_ITEMS = 450;
	localparam int          MAX_PRINTS   = 200;

	// one request transfer as queued for the driver
	typedef struct {
		logic [1:0]                   op;
		logic [pirl_pkg::POS_W-1:0]   pos;
		logic signed [31:0]           val;
		int                           phase;     // selects the idle mix
		bit                           drain;     // hold off until every response is back
	} list_req_t;

	// one response transfer as the list should give it
	typedef struct {
		pirl_pkg::status_t              status;
		logic signed [31:0]             value;
		logic                           holds_value;
		logic [pirl_pkg::COUNT_W-1:0]   entry_count;
		logic                           last;
	} list_rsp_t;

	logic                                clk;
	logic                                arst_n      = 1'b0;
	logic                                req_valid   = 1'b0;
	logic                                req_stall;
	logic [pirl_pkg::KIND_W-1:0]         kind        = '0;
	logic [pirl_pkg::POS_W-1:0]          position    = '0;
	logic signed [pirl_pkg::DATA_W-1:0]  item        = '0;
	logic                                rsp_valid;
	logic                                rsp_stall   = 1'b0;
	logic [1:0]                          status;
	logic signed [pirl_pkg::DATA_W-1:0]  value;
	logic                                holds_value;
	logic [pirl_pkg::COUNT_W-1:0]        entry_count;
	logic                                last;

	list_req_t    pending_reqs[$];
	list_rsp_t    expected_rsps[$];
	logic [31:0]  list_mem [DEPTH];     // predicted contents, only [0..list_count) used
	int           list_count = 0;
	int           gen_count  = 0;       // list length as seen while building stimulus
	int           mismatches = 0;
	int           cycles     = 0;
	logic         req_taken  = 1'b0;    // the driven request went through last edge
	int           rsp_idle_pct = 0;

	positional_insert_remove_list_core #(.DEPTH(DEPTH)) DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.kind        (kind),
		.position    (position),
		.item        (item),
		.rsp_valid   (rsp_valid),
		.rsp_stall   (rsp_stall),
		.status      (status),
		.value       (value),
		.holds_value (holds_value),
		.entry_count (entry_count),
		.last        (last)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (mismatches < MAX_PRINTS)
			$display("%0t ns: %s: got %0h, expected %0h", $realtime, what, got, want);
		mismatches++;
	endtask

	// Queue one request and keep the stimulus-side length in step, so that
	// later positions can be aimed inside or just outside the list.
	task automatic queue_req(input logic [1:0] op, input int pos, input logic [31:0] val);
		list_req_t r;
		r.op    = op;
		r.pos   = pos[pirl_pkg::POS_W-1:0];
		r.val   = val;
		r.phase = 0;
		r.drain = 1'b0;
		pending_reqs.push_back(r);
		if (op == pirl_pkg::KIND_INSERT && r.pos <= gen_count && gen_count < DEPTH)
			gen_count++;
		else if (op == pirl_pkg::KIND_REMOVE && r.pos < gen_count)
			gen_count--;
	endtask

	// Mostly full-range random values, with the sign extremes, zero and all-ones mixed in.
	function automatic logic [31:0] pick_value();
		case ($urandom_range(19))
			0:       return 32'h7fff_ffff;
			1:       return 32'h8000_0000;
			2:       return 32'h0000_0000;
			3:       return 32'hffff_ffff;
			default: return $urandom;
		endcase
	endfunction

	// Mostly in range for the operation, sometimes anywhere in the 7-bit field.
	function automatic int pick_position(input logic [1:0] op);
		if ($urandom_range(99) < 20)
			return $urandom_range(2**pirl_pkg::POS_W - 1);
		if (op == pirl_pkg::KIND_INSERT)
			return $urandom_range(gen_count);
		return (gen_count == 0) ? 0 : $urandom_range(gen_count - 1);
	endfunction

	// Apply one accepted request to the predicted list and queue the responses
	// it must produce. Index check comes before the full check on insert.
	task automatic predict_list_op(input logic [1:0] op,
			input logic [pirl_pkg::POS_W-1:0] pos, input logic [31:0] val);
		list_rsp_t r;
		int        i;
		r.status      = pirl_pkg::ST_OK;
		r.value       = '0;
		r.holds_value = 1'b0;
		r.last        = 1'b1;
		case (op)
			pirl_pkg::KIND_INSERT: begin
				if (pos > list_count)
					r.status = pirl_pkg::ST_INDEX;
				else if (list_count >= DEPTH)
					r.status = pirl_pkg::ST_FULL;
				else begin
					for (i = list_count; i > pos; i--)
						list_mem[i] = list_mem[i-1];
					list_mem[pos] = val;
					list_count++;
				end
				r.entry_count = list_count[pirl_pkg::COUNT_W-1:0];
				expected_rsps.push_back(r);
			end
			pirl_pkg::KIND_REMOVE: begin
				if (pos >= list_count)
					r.status = pirl_pkg::ST_INDEX;
				else begin
					for (i = pos; i + 1 < list_count; i++)
						list_mem[i] = list_mem[i+1];
					list_count--;
				end
				r.entry_count = list_count[pirl_pkg::COUNT_W-1:0];
				expected_rsps.push_back(r);
			end
			pirl_pkg::KIND_DUMP: begin
				r.entry_count = list_count[pirl_pkg::COUNT_W-1:0];
				if (list_count == 0)
					expected_rsps.push_back(r);
				else begin
					for (i = 0; i < list_count; i++) begin
						r.value       = list_mem[i];
						r.holds_value = 1'b1;
						r.last        = (i + 1 == list_count);
						expected_rsps.push_back(r);
					end
				end
			end
			default: begin
				// unused code: list untouched, one plain response
				r.entry_count = list_count[pirl_pkg::COUNT_W-1:0];
				expected_rsps.push_back(r);
			end
		endcase
	endtask

	// Driver: moves on at the falling edge once the current transfer went
	// through (or nothing is out), idling at the rate of the coming item's phase.
	always @(negedge clk) begin : drive_requests
		int        ph;
		list_req_t r;
		if (arst_n) begin
			ph = (pending_reqs.size() != 0) ? pending_reqs[0].phase : 2;
			if (!req_valid || req_taken) begin
				if (pending_reqs.size() != 0
						&& (!pending_reqs[0].drain || expected_rsps.size() == 0)
						&& $urandom_range(99) >= (ph == 0 ? 24 : (ph == 1 ? 50 : 0))) begin
					r = pending_reqs.pop_front();
					req_valid <= 1'b1;
					kind      <= r.op;
					position  <= r.pos;
					item      <= r.val;
				end else begin
					req_valid <= 1'b0;
				end
			end
			rsp_idle_pct = (ph == 0) ? 50 : ((ph == 1) ? 24 : 0);
			rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
		end
	end

	// Monitor: checks response transfers first, then predicts for a request
	// transfer on the same edge, so a response can never match its own request.
	always @(posedge clk) begin : watch_transfers
		list_rsp_t want;
		if (arst_n) begin
			if (rsp_valid && !rsp_stall) begin
				if (expected_rsps.size() == 0)
					report_mismatch("response with none outstanding", value, 32'h0);
				else begin
					want = expected_rsps.pop_front();
					if (status !== want.status)
						report_mismatch("status", 32'(status), 32'(want.status));
					if (value !== want.value)
						report_mismatch("value", value, want.value);
					if (holds_value !== want.holds_value)
						report_mismatch("holds_value", 32'(holds_value),
							32'(want.holds_value));
					if (entry_count !== want.entry_count)
						report_mismatch("entry_count", 32'(entry_count),
							32'(want.entry_count));
					if (last !== want.last)
						report_mismatch("last", 32'(last), 32'(want.last));
				end
			end
			if (req_valid && !req_stall)
				predict_list_op(kind, position, item);
			req_taken <= req_valid && !req_stall;
		end
	end

	always @(posedge clk) begin : watchdog
		cycles <= cycles + 1;
		if (cycles == LIMIT_CYCLES) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	initial begin : stimulus
		int  n_directed;
		int  sel;
		int  i;
		bit  filled;
		logic [1:0] op;

		// Directed: empty-list cases, both sign extremes, head/tail/middle insert,
		// head/tail remove, unused code, out-of-range positions with bit 6 set.
		queue_req(pirl_pkg::KIND_DUMP,   0, 32'h0);           // dump of an empty list
		queue_req(pirl_pkg::KIND_REMOVE, 0, 32'h0);           // remove from empty list
		queue_req(pirl_pkg::KIND_INSERT, 1, 32'h1234_5678);   // insert past the end
		queue_req(pirl_pkg::KIND_INSERT, 0, 32'h7fff_ffff);
		queue_req(pirl_pkg::KIND_INSERT, 0, 32'h8000_0000);   // new head
		queue_req(pirl_pkg::KIND_INSERT, 2, 32'hffff_ffff);   // append at count
		queue_req(pirl_pkg::KIND_INSERT, 1, 32'h0000_0000);   // middle
		queue_req(KIND_UNUSED, 127, 32'hdead_beef);
		queue_req(pirl_pkg::KIND_DUMP,   127, 32'h5555_5555);
		queue_req(pirl_pkg::KIND_REMOVE, 127, 32'h0);
		queue_req(pirl_pkg::KIND_INSERT, 127, 32'haaaa_aaaa);
		queue_req(pirl_pkg::KIND_REMOVE, 3, 32'h0);           // drop the tail
		queue_req(pirl_pkg::KIND_REMOVE, 0, 32'h0);           // drop the head
		queue_req(pirl_pkg::KIND_INSERT, 64, 32'h0f0f_0f0f);
		queue_req(pirl_pkg::KIND_DUMP,   0, 32'h0);
		queue_req(pirl_pkg::KIND_REMOVE, 1, 32'h0);
		queue_req(pirl_pkg::KIND_REMOVE, 0, 32'h0);
		queue_req(pirl_pkg::KIND_DUMP,   0, 32'h0);
		n_directed = pending_reqs.size();

		// Random: mostly single ops aimed in range, with whole fill-to-full
		// and drain-to-empty runs so the full case and long dumps show up.
		filled = 1'b0;
		while (pending_reqs.size() < n_directed + RANDOM_ITEMS) begin
			sel = $urandom_range(99);
			if (sel < 2 || (!filled && pending_reqs.size() > n_directed + 150)) begin
				filled = 1'b1;
				while (gen_count < DEPTH)
					queue_req(pirl_pkg::KIND_INSERT, $urandom_range(gen_count),
						pick_value());
				// full
				queue_req(pirl_pkg::KIND_INSERT, $urandom_range(gen_count), pick_value());
				// index wins over full
				queue_req(pirl_pkg::KIND_INSERT, gen_count + 1, pick_value());
				queue_req(pirl_pkg::KIND_DUMP, $urandom_range(127), pick_value());
			end else if (sel < 4) begin
				while (gen_count > 0)
					queue_req(pirl_pkg::KIND_REMOVE, $urandom_range(gen_count - 1),
						pick_value());
				queue_req(pirl_pkg::KIND_DUMP, 0, pick_value());
				queue_req(pirl_pkg::KIND_REMOVE, 0, pick_value());
			end else begin
				sel = $urandom_range(99);
				if (sel < 48)
					op = pirl_pkg::KIND_INSERT;
				else if (sel < 82)
					op = pirl_pkg::KIND_REMOVE;
				else if (sel < 96)
					op = pirl_pkg::KIND_DUMP;
				else
					op = KIND_UNUSED;
				queue_req(op, pick_position(op), pick_value());
			end
		end

		// Thirds of the run get the three idle mixes; the first item of each
		// later third waits until the list has answered everything before it.
		for (i = 0; i < pending_reqs.size(); i++) begin
			pending_reqs[i].phase = (i * 3) / pending_reqs.size();
			if (i > 0 && pending_reqs[i].phase != pending_reqs[i-1].phase)
				pending_reqs[i].drain = 1'b1;
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (pending_reqs.size() != 0 || req_valid)
			@(posedge clk);
		while (expected_rsps.size() != 0)
			@(posedge clk);
		// a dump may still be streaming extras past the last expected transfer
		repeat (DUMP_SETTLE) @(posedge clk);

		if (mismatches == 0 && expected_rsps.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
